[rtl/core/gsi_pkg.sv]
// ----------------------------------------------------------------------------
// Gimbal setpoint integrator package
// Item codes, fixed-point constants, stage payload types and the saturation
// and yaw wrap helpers.
// ----------------------------------------------------------------------------
package gsi_pkg;

   // Item kinds.
   localparam logic CMD_REMOTE = 1'b0;
   localparam logic CMD_AIM    = 1'b1;

   // Right switch positions.
   localparam logic [1:0] SW_UP   = 2'd0;
   localparam logic [1:0] SW_MID  = 2'd1;
   localparam logic [1:0] SW_DOWN = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STICK_GAIN  = 2'd0;
   localparam logic [1:0] CSR_MOUSE_GAIN  = 2'd1;
   localparam logic [1:0] CSR_PITCH_UPPER = 2'd2;
   localparam logic [1:0] CSR_PITCH_LOWER = 2'd3;

   // Q8.24 constants.
   localparam logic signed [32:0] Q_OFF_005  = 33'sd838861;
   localparam logic signed [33:0] Q_PI       = 34'sd52707179;
   localparam logic signed [33:0] Q_TWO_PI   = 34'sd105414357;
   localparam int                 WRAP_STEPS = 20;

   // Reset values of the configuration and the derived pitch limits.
   localparam logic [15:0]        GAIN_RESET     = 16'd5243;
   localparam logic signed [31:0] PITCH_HI_RESET = 32'sd11320762;
   localparam logic signed [31:0] PITCH_LO_RESET = -32'sd6731858;

   // Increment width: a Q8.24 step saturated to well beyond the int32 range.
   localparam int INC_W = 34;

   typedef struct packed {
      logic                    cmd;
      logic [1:0]              sw;
      logic                    target;
      logic                    stick_mode;
      logic signed [INC_W-1:0] yaw_inc;
      logic signed [INC_W-1:0] pitch_inc;
   } s1_type;

   typedef struct packed {
      logic               wrap;
      logic signed [31:0] yaw;
      logic signed [31:0] pitch;
   } s2_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sd2147483647)       r = 32'sh7FFF_FFFF;
      else if (v < -33'sd2147483648) r = 32'sh8000_0000;
      else                           r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647)       r = 32'sh7FFF_FFFF;
      else if (v < -35'sd2147483648) r = 32'sh8000_0000;
      else                           r = v[31:0];
      return r;
   endfunction

   // Product of count and gain (Q.16) moved to Q8.24. Products beyond 26 bits
   // saturate any accumulator anyway, so they are clamped first.
   function automatic logic signed [INC_W-1:0] scale_inc(input logic signed [32:0] p);
      logic signed [25:0] c;
      if (p > 33'sd33554431)       c = 26'sh1FF_FFFF;
      else if (p < -33'sd33554432) c = 26'sh200_0000;
      else                         c = p[25:0];
      return {c, 8'd0};
   endfunction

   // Brings yaw into [-pi, pi] by the fewest whole turns.
   function automatic logic signed [31:0] wrap_yaw(input logic signed [31:0] y);
      logic signed [33:0] yw;
      logic signed [33:0] r;
      yw = INC_W'(y);
      r  = yw;
      for (int j = 1; j <= WRAP_STEPS; j++) begin
         if (yw > Q_PI + INC_W'(j - 1) * Q_TWO_PI) begin
            r = yw - INC_W'(j) * Q_TWO_PI;
         end
         if (yw < -Q_PI - INC_W'(j - 1) * Q_TWO_PI) begin
            r = yw + INC_W'(j) * Q_TWO_PI;
         end
      end
      return r[31:0];
   endfunction

endpackage

[rtl/core/gimbal_setpoint_integrator_top.sv]
// ----------------------------------------------------------------------------
// Gimbal setpoint integrator
// Integrates stick, mouse and auto-aim corrections into saturating Q8.24 yaw
// and pitch setpoints and emits them, with yaw wrapped for auto-aim items.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | tuser: cmd, target; tdata: fields
//  rsp     | out       | rsp_tvalid/tready  | tdata: yaw_out, pitch_out
//  csr     | in        | csr_we             | csr_addr, csr_wdata
//
// One item is accepted per cycle while the output is not stalled.
// Stage one registers the gain products, stage two updates the accumulators
// (this is the only feedback loop), stage three wraps yaw into the output.
// Reset clears the setpoints, sets the switch to down and loads default gains.
// A stalled output holds the stages behind it; each stage keeps its item.
// ----------------------------------------------------------------------------
module gimbal_setpoint_integrator_top
   import gsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [0] cmd, [1] target_present
   input  logic [1:0]   req_tuser,
   // switch_right, stick_x, stick_y, mouse_dx, mouse_dy, aim_yaw_delta,
   // aim_pitch_delta
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // yaw_out, pitch_out
   output logic [63:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   logic [1:0]         in_switch_right;
   logic signed [10:0] in_stick_x;
   logic signed [10:0] in_stick_y;
   logic signed [15:0] in_mouse_dx;
   logic signed [15:0] in_mouse_dy;
   logic signed [31:0] in_aim_yaw;
   logic signed [31:0] in_aim_pitch;

   assign in_switch_right = req_tdata[1:0];
   assign in_stick_x      = req_tdata[12:2];
   assign in_stick_y      = req_tdata[23:13];
   assign in_mouse_dx     = req_tdata[39:24];
   assign in_mouse_dy     = req_tdata[55:40];
   assign in_aim_yaw      = req_tdata[87:56];
   assign in_aim_pitch    = req_tdata[119:88];

   // Configuration; the pitch limits are kept already pulled in by 0.05 rad.
   logic [15:0]        stick_gain_ff;
   logic [15:0]        mouse_gain_ff;
   logic signed [31:0] pitch_hi_ff;
   logic signed [31:0] pitch_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_gain_ff <= GAIN_RESET;
         mouse_gain_ff <= GAIN_RESET;
         pitch_hi_ff   <= PITCH_HI_RESET;
         pitch_lo_ff   <= PITCH_LO_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STICK_GAIN:  stick_gain_ff <= csr_wdata[15:0];
            CSR_MOUSE_GAIN:  mouse_gain_ff <= csr_wdata[15:0];
            CSR_PITCH_UPPER: pitch_hi_ff   <= sat33(33'($signed(csr_wdata)) - Q_OFF_005);
            CSR_PITCH_LOWER: pitch_lo_ff   <= sat33(33'($signed(csr_wdata)) + Q_OFF_005);
            default: ;
         endcase
      end
   end

   // Handshake between the stages.
   logic   s1_valid_ff, s1_valid_in;
   logic   s2_valid_ff, s2_valid_in;
   logic   rsp_valid_ff, rsp_valid_in;
   logic   s3_free, s2_free, s1_go;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   assign s3_free    = !rsp_valid_ff || rsp_tready;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_go      = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;

   // Stage one: choose the stick or the mouse and multiply by its gain.
   logic               stick_mode;
   logic signed [15:0] mul_yaw_cnt, mul_pitch_cnt;
   logic signed [16:0] mul_gain;
   logic signed [32:0] prod_yaw, prod_pitch;

   always_comb begin
      stick_mode    = (in_mouse_dx == 16'sd0) && (in_mouse_dy == 16'sd0);
      mul_yaw_cnt   = stick_mode ? 16'(in_stick_x) : in_mouse_dx;
      mul_pitch_cnt = stick_mode ? 16'(in_stick_y) : in_mouse_dy;
      mul_gain      = $signed({1'b0, stick_mode ? stick_gain_ff : mouse_gain_ff});
      prod_yaw      = 33'(mul_yaw_cnt) * 33'(mul_gain);
      prod_pitch    = 33'(mul_pitch_cnt) * 33'(mul_gain);

      s1_in.cmd        = req_tuser[0];
      s1_in.target     = req_tuser[1];
      s1_in.sw         = in_switch_right;
      s1_in.stick_mode = stick_mode;
      if (req_tuser[0] == CMD_AIM) begin
         s1_in.yaw_inc   = INC_W'(in_aim_yaw);
         s1_in.pitch_inc = INC_W'(in_aim_pitch);
      end else begin
         s1_in.yaw_inc   = scale_inc(prod_yaw);
         s1_in.pitch_inc = scale_inc(prod_pitch);
      end
      s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) s1_ff <= s1_in;
   end

   // Stage two: saturating accumulate, stick-mode pitch clamp, switch state.
   logic signed [31:0] yaw_acc_ff, yaw_acc_in;
   logic signed [31:0] pitch_acc_ff, pitch_acc_in;
   logic [1:0]         switch_ff, switch_in;
   logic signed [31:0] yaw_sum, pitch_sum, pitch_lim;
   logic               emit;

   always_comb begin
      yaw_sum   = sat35(35'(yaw_acc_ff) + 35'(s1_ff.yaw_inc));
      pitch_sum = sat35(35'(pitch_acc_ff) + 35'(s1_ff.pitch_inc));
      pitch_lim = pitch_sum;
      if (s1_ff.cmd == CMD_REMOTE && s1_ff.stick_mode) begin
         if (pitch_lim >= pitch_hi_ff) pitch_lim = pitch_hi_ff;
         if (pitch_lim <= pitch_lo_ff) pitch_lim = pitch_lo_ff;
      end

      if (s1_ff.cmd == CMD_REMOTE) begin
         emit = (s1_ff.sw == SW_UP) || (s1_ff.sw == SW_MID);
      end else begin
         emit = s1_ff.target && (switch_ff == SW_UP);
      end

      yaw_acc_in   = yaw_acc_ff;
      pitch_acc_in = pitch_acc_ff;
      switch_in    = switch_ff;
      if (s1_go) begin
         if (s1_ff.cmd == CMD_REMOTE) switch_in = s1_ff.sw;
         if (emit) begin
            yaw_acc_in   = yaw_sum;
            pitch_acc_in = pitch_lim;
         end
      end

      s2_in.wrap  = (s1_ff.cmd == CMD_AIM);
      s2_in.yaw   = yaw_sum;
      s2_in.pitch = pitch_lim;
      s2_valid_in = s2_free ? (s1_valid_ff && emit) : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_acc_ff   <= '0;
         pitch_acc_ff <= '0;
         switch_ff    <= SW_DOWN;
         s2_valid_ff  <= 1'b0;
      end else begin
         yaw_acc_ff   <= yaw_acc_in;
         pitch_acc_ff <= pitch_acc_in;
         switch_ff    <= switch_in;
         s2_valid_ff  <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) s2_ff <= s2_in;
   end

   // Stage three: yaw wrap for auto-aim results into the output register.
   always_comb begin
      rsp_data_in[31:0]  = s2_ff.wrap ? wrap_yaw(s2_ff.yaw) : s2_ff.yaw;
      rsp_data_in[63:32] = s2_ff.pitch;
      rsp_valid_in       = s3_free ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s3_free && s2_valid_ff) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The setpoints move only when an item leaves stage one.
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_go |=> $stable(yaw_acc_ff) && $stable(pitch_acc_ff))
      else $error("setpoint changed without an item");

   // After a stick-mode update pitch never sits below the lower limit.
   a_pitch_clamp: assert property (@(posedge clock) disable iff (reset)
      (s1_go && emit && s1_ff.cmd == CMD_REMOTE && s1_ff.stick_mode)
      |=> (pitch_acc_ff >= pitch_lo_ff))
      else $error("stick-mode pitch below lower limit");

   // A wrapped yaw lands within plus or minus pi.
   a_yaw_wrap: assert property (@(posedge clock) disable iff (reset)
      (s3_free && s2_valid_ff && s2_ff.wrap)
      |=> (34'($signed(rsp_tdata[31:0])) <= Q_PI)
          && (34'($signed(rsp_tdata[31:0])) >= -Q_PI))
      else $error("wrapped yaw out of range");

   // A remote-control item always leaves its switch position behind.
   a_switch_store: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_ff.cmd == CMD_REMOTE) |=> (switch_ff == $past(s1_ff.sw)))
      else $error("switch position not stored");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Gimbal setpoint integrator testbench
// Sends remote-control and auto-aim items over the request stream and keeps
// its own yaw and pitch setpoints. Every result is checked against them, in
// order. Both sides idle at random in some phases. The gains and pitch
// limits are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import gsi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  SW_SPARE      = 2'd3;
   localparam longint      PITCH_MARGIN  = 838861;
   localparam longint      HALF_TURN     = 52707179;
   localparam longint      FULL_TURN     = 105414357;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          STALL_CYCLES  = 120;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   // Laid out exactly as on req_tdata, the switch in the lowest bits.
   typedef struct packed {
      logic signed [31:0] aim_pitch_delta;
      logic signed [31:0] aim_yaw_delta;
      logic signed [15:0] mouse_dy;
      logic signed [15:0] mouse_dx;
      logic signed [10:0] stick_y;
      logic signed [10:0] stick_x;
      logic [1:0]         sw;
   } ctrl_fields_type;

   // {target, cmd} is req_tuser.
   typedef struct packed {
      logic            target;
      logic            cmd;
      ctrl_fields_type f;
   } ctrl_item_type;

   typedef struct packed {
      logic signed [31:0] pitch;
      logic signed [31:0] yaw;
   } setpoint_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [119:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [31:0]  csr_wdata = '0;

   // Predicted block state and register copies.
   logic signed [31:0] yaw_track = '0;
   logic signed [31:0] pitch_track = '0;
   logic [1:0]         held_switch = SW_DOWN;
   logic [15:0]        stick_gain_q = GAIN_RESET;
   logic [15:0]        mouse_gain_q = GAIN_RESET;
   logic signed [31:0] pitch_upper_q = 32'sd12159623;
   logic signed [31:0] pitch_lower_q = -32'sd7570719;

   ctrl_item_type commands_pending[$];
   setpoint_type  setpoints_due[$];
   ctrl_item_type next_cmd;
   setpoint_type  predicted;
   setpoint_type  observed;
   setpoint_type  wanted;
   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          hold_left = 0;
   int          stall_asks = 0;
   int          stall_seen = 0;
   int          mismatches = 0;
   int unsigned cycles = 0;

   gimbal_setpoint_integrator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic signed [31:0] clip_q824(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return 32'(v);
   endfunction

   // Updates the setpoints for one item; returns 1 when the item yields a result.
   function automatic bit integrate_command(input ctrl_item_type it,
                                            output setpoint_type sp);
      longint step_gain;
      longint yaw_l;
      longint hi;
      longint lo;
      sp = '0;
      if (it.cmd == CMD_REMOTE) begin
         held_switch = it.f.sw;
         if (it.f.sw != SW_UP && it.f.sw != SW_MID) return 1'b0;
         if (it.f.mouse_dx == 0 && it.f.mouse_dy == 0) begin
            step_gain   = longint'(stick_gain_q) * 256;
            yaw_track   = clip_q824(longint'(yaw_track) + longint'(it.f.stick_x) * step_gain);
            pitch_track = clip_q824(longint'(pitch_track) + longint'(it.f.stick_y) * step_gain);
            hi = clip_q824(longint'(pitch_upper_q) - PITCH_MARGIN);
            lo = clip_q824(longint'(pitch_lower_q) + PITCH_MARGIN);
            // With crossed limits the lower one is applied last and wins.
            if (longint'(pitch_track) >= hi) pitch_track = 32'(hi);
            if (longint'(pitch_track) <= lo) pitch_track = 32'(lo);
         end else begin
            step_gain   = longint'(mouse_gain_q) * 256;
            yaw_track   = clip_q824(longint'(yaw_track) + longint'(it.f.mouse_dx) * step_gain);
            pitch_track = clip_q824(longint'(pitch_track) + longint'(it.f.mouse_dy) * step_gain);
         end
         sp.yaw = yaw_track;
      end else begin
         if (!it.target || held_switch != SW_UP) return 1'b0;
         yaw_track   = clip_q824(longint'(yaw_track) + longint'(it.f.aim_yaw_delta));
         pitch_track = clip_q824(longint'(pitch_track) + longint'(it.f.aim_pitch_delta));
         // Only the emitted yaw is wrapped; the setpoint keeps the plain sum.
         yaw_l = yaw_track;
         if (yaw_l > HALF_TURN)
            yaw_l -= ((yaw_l - HALF_TURN + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
         else if (yaw_l < -HALF_TURN)
            yaw_l += ((-HALF_TURN - yaw_l + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
         sp.yaw = 32'(yaw_l);
      end
      sp.pitch = pitch_track;
      return 1'b1;
   endfunction

   function automatic logic signed [10:0] draw_stick();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 11'sd660 : -11'sd660;
      return 11'(int'($urandom_range(0, 1320)) - 660);
   endfunction

   function automatic logic signed [15:0] draw_mouse();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 16'(int'($urandom_range(0, 128)) - 64);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [31:0] draw_angle();
      case ($urandom_range(0, 7))
         0, 1: return 32'($urandom);
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      endcase
   endfunction

   function automatic ctrl_item_type make_remote(input logic [1:0] sw,
                                                  input logic signed [10:0] sx, sy,
                                                  input logic signed [15:0] mx, my);
      ctrl_item_type it;
      it.cmd               = CMD_REMOTE;
      it.target            = 1'($urandom);
      it.f.sw              = sw;
      it.f.stick_x         = sx;
      it.f.stick_y         = sy;
      it.f.mouse_dx        = mx;
      it.f.mouse_dy        = my;
      it.f.aim_yaw_delta   = 32'($urandom);
      it.f.aim_pitch_delta = 32'($urandom);
      return it;
   endfunction

   function automatic ctrl_item_type make_aim(input bit tgt, input logic signed [31:0] dy, dp);
      ctrl_item_type it;
      it.cmd               = CMD_AIM;
      it.target            = tgt;
      it.f.sw              = 2'($urandom);
      it.f.stick_x         = draw_stick();
      it.f.stick_y         = draw_stick();
      it.f.mouse_dx        = draw_mouse();
      it.f.mouse_dy        = draw_mouse();
      it.f.aim_yaw_delta   = dy;
      it.f.aim_pitch_delta = dp;
      return it;
   endfunction

   function automatic ctrl_item_type draw_command();
      int unsigned pick;
      logic [1:0]  sw;
      if ($urandom_range(0, 99) < 55) begin
         pick = $urandom_range(0, 99);
         sw = (pick < 45) ? SW_UP : (pick < 80) ? SW_MID : (pick < 92) ? SW_DOWN : SW_SPARE;
         if ($urandom_range(0, 1)) return make_remote(sw, draw_stick(), draw_stick(), '0, '0);
         return make_remote(sw, draw_stick(), draw_stick(), draw_mouse(), draw_mouse());
      end
      return make_aim($urandom_range(0, 9) != 0, draw_angle(), draw_angle());
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // Waits until every item is taken and every result has come, then lets
   // items without a result run out of the pipeline.
   task automatic settle();
      while (commands_pending.size() != 0 || req_tvalid || setpoints_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] sg, mg,
                                 input logic signed [31:0] upper, lower);
      logic [1:0]  regs [4];
      logic [31:0] vals [4];
      regs = '{CSR_STICK_GAIN, CSR_MOUSE_GAIN, CSR_PITCH_UPPER, CSR_PITCH_LOWER};
      // Gain writes carry junk in the upper half, which must be dropped.
      vals = '{{16'($urandom), sg}, {16'($urandom), mg}, upper, lower};
      for (int k = 0; k < 4; k++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= regs[k];
         csr_wdata <= vals[k];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      stick_gain_q  = sg;
      mouse_gain_q  = mg;
      pitch_upper_q = upper;
      pitch_lower_q = lower;
   endtask

   task automatic run_phase(input int count, input bit idle_req, idle_rsp);
      req_idle_on = idle_req;
      rsp_idle_on = idle_rsp;
      repeat (count) commands_pending.push_back(draw_command());
      settle();
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (commands_pending.size() != 0) begin
            next_cmd = commands_pending.pop_front();
            req_tuser  <= {next_cmd.target, next_cmd.cmd};
            req_tdata  <= next_cmd.f;
            req_tvalid <= 1'b1;
            req_gap = req_idle_on ? $urandom_range(0, 3) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver, with the long hold-off counted here.
   always @(negedge clock) begin
      if (stall_asks != stall_seen) begin
         stall_seen = stall_asks;
         hold_left  = STALL_CYCLES;
      end
      if (rsp_taken) rsp_gap = rsp_idle_on ? $urandom_range(0, 3) : 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on every accepted item, checks every accepted result.
   always @(posedge clock) begin
      cycles    <= cycles + 1;
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready) begin
         if (integrate_command(ctrl_item_type'({req_tuser, req_tdata}), predicted))
            setpoints_due.push_back(predicted);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed = rsp_tdata;
         if (setpoints_due.size() == 0) begin
            report_mismatch($sformatf("result %h with none expected", rsp_tdata));
         end else begin
            wanted = setpoints_due.pop_front();
            if (observed.yaw !== wanted.yaw)
               report_mismatch($sformatf("yaw_out %0d, expected %0d",
                                         observed.yaw, wanted.yaw));
            if (observed.pitch !== wanted.pitch)
               report_mismatch($sformatf("pitch_out %0d, expected %0d",
                                         observed.pitch, wanted.pitch));
         end
      end
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("TIMEOUT after %0d cycles", cycles);
      $display("gimbal_setpoint_integrator_top regression: fail");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items under reset settings. The switch starts down, so aim
      // items are ignored until an up position has been stored.
      commands_pending.push_back(make_aim(1'b1, 32'sd1000000, 32'sd1000000));
      commands_pending.push_back(make_remote(SW_UP, 11'sd660, 11'sd660, '0, '0));
      commands_pending.push_back(make_remote(SW_MID, -11'sd660, -11'sd660, '0, '0));
      commands_pending.push_back(make_remote(SW_UP, '0, '0, '0, '0));
      commands_pending.push_back(make_remote(SW_UP, 11'sd300, -11'sd300, 16'sh7FFF, '0));
      commands_pending.push_back(make_remote(SW_MID, 11'sd5, 11'sd5, '0, 16'sh8000));
      commands_pending.push_back(make_remote(SW_UP, '0, '0, 16'sh8000, 16'sh7FFF));
      commands_pending.push_back(make_remote(SW_DOWN, 11'sd100, 11'sd100, '0, '0));
      commands_pending.push_back(make_aim(1'b1, 32'sd2000000, -32'sd2000000));
      // The spare switch code is stored but is neither up nor mid.
      commands_pending.push_back(make_remote(SW_SPARE, 11'sd100, 11'sd100, '0, '0));
      commands_pending.push_back(make_aim(1'b1, 32'sd2000000, 32'sd2000000));
      commands_pending.push_back(make_remote(SW_MID, 11'sd10, -11'sd10, '0, '0));
      commands_pending.push_back(make_aim(1'b1, 32'sd2000000, 32'sd2000000));
      commands_pending.push_back(make_remote(SW_UP, 11'sd660, -11'sd660, '0, '0));
      commands_pending.push_back(make_aim(1'b0, 32'sd3000000, 32'sd3000000));
      commands_pending.push_back(make_aim(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      commands_pending.push_back(make_aim(1'b1, 32'sh8000_0000, 32'sh8000_0000));
      commands_pending.push_back(make_aim(1'b1, 32'sh8000_0000, 32'sh8000_0000));
      commands_pending.push_back(make_aim(1'b1, '0, '0));
      commands_pending.push_back(make_aim(1'b1, 32'sd60000000, -32'sd5000000));
      commands_pending.push_back(make_aim(1'b1, -32'sd250000000, 32'sd9000000));
      commands_pending.push_back(make_remote(SW_UP, -11'sd660, 11'sd660, '0, '0));
      commands_pending.push_back(make_remote(SW_UP, '0, '0, '0, '0));
      settle();

      run_phase(180, 1'b1, 1'b1);

      apply_settings(16'd0, 16'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
      run_phase(120, 1'b0, 1'b0);

      // Both clamp limits saturate and cross.
      apply_settings(16'hFFFF, 16'hFFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      run_phase(120, 1'b1, 1'b1);

      // Receiver holds off while items keep coming, so the block backs up.
      apply_settings(GAIN_RESET, 16'd900, 32'sd4000000, 32'sd9000000);
      stall_asks++;
      run_phase(40, 1'b0, 1'b0);

      for (int p = 0; p < 4; p++) begin
         if (p % 2 == 0)
            apply_settings(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                           32'($urandom_range(4000000, 25000000)),
                           -32'($urandom_range(4000000, 25000000)));
         else
            apply_settings(16'($urandom), 16'($urandom), draw_angle(), draw_angle());
         run_phase(90, p % 2 == 1, 1'($urandom));
      end

      if (mismatches == 0)
         $display("gimbal_setpoint_integrator_top regression: pass");
      else
         $display("gimbal_setpoint_integrator_top regression: fail");
      $finish;
   end

endmodule

[gimbal_setpoint_integrator_top.f]
rtl/core/gsi_pkg.sv
rtl/core/gimbal_setpoint_integrator_top.sv
tb/testbench.sv
